### hw/rtl/qsv_pkg.sv
// Package for the state-vector gate engine: opcodes and status codes.
// No dependencies; imported by the engine top level and its port checker.
package qsv_pkg;

	localparam logic [2:0] OP_INIT  = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_GATE1 = 3'd2;
	localparam logic [2:0] OP_GATE2 = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_QUBIT = 2'd1,
		ST_EQUAL     = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

endpackage

### hw/rtl/quantum_state_vector_gate_engine_top.sv
// State-vector gate engine top level; uses qsv_pkg. One item at a time, one result beat each.
// Init sweeps all 2^MAX_QUBITS amplitude words (clearing sweep); a one-qubit gate works through
// (2^n / 2) groups of two amplitudes and a two-qubit gate (2^n / 4) groups of four. Rate is set
// by the single complex multiply unit (one coefficient x amplitude per cycle) and the amplitude
// memory with one read and one write port. Async active-low reset clears control state only;
// amplitude and coefficient memories hold garbage until init and load.
module quantum_state_vector_gate_engine_top
	import qsv_pkg::*;
#(
	parameter int MAX_QUBITS = 10,
	parameter int AMP_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        num_qubits_we,
	input  logic [3:0]  num_qubits_wdata,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  opcode,
	input  logic [5:0]  qubit_a,
	input  logic [5:0]  qubit_b,
	input  logic [3:0]  entry_index,
	input  logic [31:0] coeff_re,
	input  logic [31:0] coeff_im,
	input  logic [9:0]  amp_index,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [31:0] amp_re,
	output logic [31:0] amp_im
);

	localparam int W     = AMP_WIDTH;
	localparam int FRAC  = W - 2;
	localparam int PW    = 2 * W;
	localparam int ACC_W = W + 5;
	localparam int AW    = MAX_QUBITS;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = $clog2(MAX_QUBITS + 1);
	localparam int CW    = (AW + 1 > 4) ? AW + 1 : 4;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
	localparam logic [PW-1:0] ONE_WORD = PW'(64'd1 << (FRAC + W));

	typedef enum logic [2:0] {
		S_IDLE, S_CLEAR, S_RD, S_MAC, S_DRAIN, S_WR, S_RDW, S_RESP
	} state_t;

	state_t            state_q;
	logic [3:0]        num_qubits_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     grp_q;
	logic [5:0]        lo_q, hi_q;
	logic              two_q;
	status_t           res_status_q;
	logic [31:0]       res_re_q, res_im_q;
	logic              result_valid_q;
	status_t           status_q;
	logic [31:0]       amp_re_q, amp_im_q;
	logic              v_s1, v_s2;

	logic [PW-1:0]     amp_mem [DEPTH];
	logic [PW-1:0]     mat_mem [16];
	logic [PW-1:0]     rd_q;
	logic [PW-1:0]     in_q [4];
	logic [PW-1:0]     o_q [4];

	logic [PW-1:0]     mat_s1, a_s1;
	logic [1:0]        row_s1, row_s2;
	logic              first_s1, last_s1, first_s2, last_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;

	logic [NW-1:0]     n_eff;
	logic [AW:0]       dim;
	logic              accept;
	logic [AW-1:0]     base_idx, bit_lo, bit_hi, slot_idx, rd_addr;
	logic [1:0]        col, row;
	logic              grp_last;
	logic [CW-1:0]     k_cnt, kk_cnt;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [PW-1:0]     mem_wd;
	logic [5:0]        q_lo, q_hi;
	logic              read_ok;
	logic signed [ACC_W-1:0] term_re, term_im, sum_re, sum_im;

	function automatic logic [AW-1:0] ins0(input logic [AW-1:0] v, input logic [5:0] p);
		logic [AW-1:0] lowm;
		lowm = (AW'(1) << p) - AW'(1);
		return ((v >> p) << (p + 6'd1)) | (v & lowm);
	endfunction

	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + (PW'(1) << (FRAC - 1));
		return ACC_W'(t >>> FRAC);
	endfunction

	function automatic logic [W-1:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > SAT_HI) r = SAT_HI;
		else if (v < SAT_LO) r = SAT_LO;
		else r = v;
		return r[W-1:0];
	endfunction

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign amp_re       = amp_re_q;
	assign amp_im       = amp_im_q;

	always_comb begin
		if (32'(num_qubits_q) > 32'(MAX_QUBITS)) n_eff = NW'(MAX_QUBITS);
		else n_eff = NW'(num_qubits_q);
		dim     = (AW + 1)'(1) << n_eff;
		q_lo    = (qubit_a < qubit_b) ? qubit_a : qubit_b;
		q_hi    = (qubit_a < qubit_b) ? qubit_b : qubit_a;
		read_ok = ((32'(amp_index) >> n_eff) == 32'd0);
		bit_lo  = AW'(1) << lo_q;
		bit_hi  = AW'(1) << hi_q;
		base_idx = two_q ? ins0(ins0(grp_q, lo_q), hi_q) : ins0(grp_q, lo_q);
		slot_idx = base_idx | (cnt_q[0] ? bit_lo : '0) | ((cnt_q[1] && two_q) ? bit_hi : '0);
		rd_addr  = (state_q == S_IDLE) ? AW'(amp_index) : slot_idx;
		col      = two_q ? cnt_q[1:0] : {1'b0, cnt_q[0]};
		row      = two_q ? cnt_q[3:2] : {1'b0, cnt_q[1]};
		k_cnt    = two_q ? CW'(4) : CW'(2);
		kk_cnt   = two_q ? CW'(16) : CW'(4);
		grp_last = ((((AW + 1)'(grp_q) + (AW + 1)'(1)) << (two_q ? 2'd2 : 2'd1)) == dim);
		mem_we = 1'b0;
		mem_wa = slot_idx;
		mem_wd = o_q[cnt_q[1:0]];
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = cnt_q[AW-1:0];
			mem_wd = (cnt_q == '0) ? ONE_WORD : '0;
		end else if (state_q == S_WR) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		term_re = rnd(p_rr_s2) - rnd(p_ii_s2);
		term_im = rnd(p_ri_s2) + rnd(p_ir_s2);
		sum_re  = first_s2 ? term_re : acc_re_q + term_re;
		sum_im  = first_s2 ? term_im : acc_im_q + term_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			num_qubits_q   <= 4'd1;
			cnt_q          <= '0;
			grp_q          <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			two_q          <= 1'b0;
			res_status_q   <= ST_OK;
			res_re_q       <= '0;
			res_im_q       <= '0;
			result_valid_q <= 1'b0;
			status_q       <= ST_OK;
			amp_re_q       <= '0;
			amp_im_q       <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
		end else begin
			if (num_qubits_we) num_qubits_q <= num_qubits_wdata;
			v_s1 <= (state_q == S_MAC);
			v_s2 <= v_s1;
			if (state_q == S_RESP && (!result_valid_q || result_ready))
				result_valid_q <= 1'b1;
			else if (result_valid_q && result_ready)
				result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_re_q <= '0;
						res_im_q <= '0;
						cnt_q    <= '0;
						grp_q    <= '0;
						unique case (opcode)
							OP_INIT: begin
								res_status_q <= ST_OK;
								state_q      <= S_CLEAR;
							end
							OP_GATE1: begin
								lo_q  <= qubit_a;
								two_q <= 1'b0;
								if (qubit_a >= 6'(n_eff)) begin
									res_status_q <= ST_BAD_QUBIT;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_RD;
								end
							end
							OP_GATE2: begin
								lo_q  <= q_lo;
								hi_q  <= q_hi;
								two_q <= 1'b1;
								priority if (qubit_a == qubit_b) begin
									res_status_q <= ST_EQUAL;
									state_q      <= S_RESP;
								end else if (q_hi >= 6'(n_eff)) begin
									res_status_q <= ST_BAD_QUBIT;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_RD;
								end
							end
							OP_READ: begin
								if (read_ok) begin
									res_status_q <= ST_OK;
									state_q      <= S_RDW;
								end else begin
									res_status_q <= ST_RANGE;
									state_q      <= S_RESP;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DEPTH - 1)) state_q <= S_RESP;
				end
				S_RD: begin
					if (cnt_q == k_cnt) begin
						cnt_q   <= '0;
						state_q <= S_MAC;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_MAC: begin
					if (cnt_q == kk_cnt - CW'(1)) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) state_q <= S_WR;
				end
				S_WR: begin
					if (cnt_q == k_cnt - CW'(1)) begin
						cnt_q <= '0;
						if (grp_last) begin
							state_q <= S_RESP;
						end else begin
							grp_q   <= grp_q + AW'(1);
							state_q <= S_RD;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_RDW: begin
					res_re_q <= 32'($signed(rd_q[PW-1:W]));
					res_im_q <= 32'($signed(rd_q[W-1:0]));
					state_q  <= S_RESP;
				end
				S_RESP: begin
					// hold the result until the output register is free
					if (!result_valid_q || result_ready) begin
						status_q <= res_status_q;
						amp_re_q <= res_re_q;
						amp_im_q <= res_im_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// memories and the shared complex multiply-accumulate datapath
	always_ff @(posedge clk) begin
		if (mem_we) amp_mem[mem_wa] <= mem_wd;
		rd_q <= amp_mem[rd_addr];
		if (accept && opcode == OP_LOAD)
			mat_mem[entry_index] <= {coeff_re[W-1:0], coeff_im[W-1:0]};
		if (state_q == S_RD && cnt_q != '0)
			in_q[2'(cnt_q - CW'(1))] <= rd_q;

		mat_s1   <= mat_mem[cnt_q[3:0]];
		a_s1     <= in_q[col];
		row_s1   <= row;
		first_s1 <= (col == 2'd0);
		last_s1  <= two_q ? (col == 2'd3) : (col == 2'd1);

		p_rr_s2  <= $signed(mat_s1[PW-1:W]) * $signed(a_s1[PW-1:W]);
		p_ii_s2  <= $signed(mat_s1[W-1:0])  * $signed(a_s1[W-1:0]);
		p_ri_s2  <= $signed(mat_s1[PW-1:W]) * $signed(a_s1[W-1:0]);
		p_ir_s2  <= $signed(mat_s1[W-1:0])  * $signed(a_s1[PW-1:W]);
		row_s2   <= row_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;

		if (v_s2) begin
			acc_re_q <= sum_re;
			acc_im_q <= sum_im;
			if (last_s2) o_q[row_s2] <= {sat(sum_re), sat(sum_im)};
		end
	end

endmodule

### hw/rtl/qsv_checker.sv
// Port checker for the state-vector gate engine, bound to its top level.
// Depends on qsv_pkg for status codes.
module qsv_checker
	import qsv_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic [31:0] amp_re,
	input logic [31:0] amp_im
);

	// a waiting result beat stays
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status))
		else $error("result beat dropped while stalled");

	// error beats carry no amplitude
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> amp_re == 32'd0 && amp_im == 32'd0)
		else $error("nonzero amplitude on error status");

	// busy right after an accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous still in flight");

endmodule

bind quantum_state_vector_gate_engine_top qsv_checker u_qsv_checker (.*);
